// ----- design/sid_pkg.sv -----
// shared types and constants of the signed integer divider
package sid_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;

  localparam logic [DATA_W-1:0] QUOT_MAX = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]  LAST_STEP = 5'd31;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

// ----- design/sid_if.sv -----
// valid/ready channel interfaces for operands and results
interface sid_in_if;
  logic            valid;
  logic            ready;
  sid_pkg::word_t  dividend;
  sid_pkg::word_t  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sid_out_if;
  logic            valid;
  logic            ready;
  sid_pkg::word_t  quotient;
  logic            div_by_zero;

  modport source (output valid, output quotient, output div_by_zero, input ready);
  modport sink   (input valid, input quotient, input div_by_zero, output ready);
endinterface

// ----- design/signed_integer_divider_core.sv -----
// signed 32-bit divider, radix-2 restoring, one quotient bit per cycle
//
// in_chan carries a dividend and a divisor; out_chan returns the quotient
// truncated toward zero and a divide-by-zero flag. Both use valid/ready and
// a transfer happens on a clock edge where both are high.
// The transfer edge loads the magnitudes, then the shift-subtract loop forms
// one quotient bit per cycle through a 33-bit subtractor, and a sign fixup
// writes the result into the output register once that register is free.
// The loop handles one item at a time and in_chan.ready is high only while
// the loop is free, so a new operand pair waits until the last one is done.
// A zero divisor yields quotient 0 with div_by_zero set; the most negative
// value divided by -1 saturates to 2147483647.
// The result sits in an output register, so a new operand pair is taken
// while an earlier result still waits. If the receiver stalls longer than
// the loop takes, the finished quotient waits in the loop and input stays
// blocked until the output register is free.
// Reset (rst_n low, synchronous) empties the loop and the output register.
module signed_integer_divider_core (
  input  logic      clk,
  input  logic      rst_n,
  sid_in_if.sink    in_chan,
  sid_out_if.source out_chan
);

  sid_pkg::state_t state_r, state_nxt;

  logic [sid_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [sid_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [sid_pkg::DATA_W-1:0] den_r, den_nxt;
  logic [sid_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       neg_r, neg_nxt;
  logic                       dbz_r, dbz_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [sid_pkg::DATA_W-1:0] out_quot_r, out_quot_nxt;
  logic                       out_dbz_r, out_dbz_nxt;

  logic                       in_xfer;
  logic                       out_free;
  logic [sid_pkg::DATA_W:0]   trial;
  logic [sid_pkg::DATA_W-1:0] q_fixed;

  assign in_chan.ready = (state_r == sid_pkg::ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.quotient    = out_quot_r;
  assign out_chan.div_by_zero = out_dbz_r;

  // shifted partial remainder minus divisor; top bit set means borrow
  assign trial = {rem_r, quo_r[sid_pkg::DATA_W-1]} - {1'b0, den_r};

  always_comb begin
    if (neg_r) begin
      q_fixed = ~quo_r + 1'b1;
    end else if (quo_r[sid_pkg::DATA_W-1]) begin
      q_fixed = sid_pkg::QUOT_MAX;
    end else begin
      q_fixed = quo_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    dbz_nxt       = dbz_r;
    out_valid_nxt = out_valid_r;
    out_quot_nxt  = out_quot_r;
    out_dbz_nxt   = out_dbz_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sid_pkg::ST_IDLE: begin
        if (in_xfer) begin
          quo_nxt   = in_chan.dividend[sid_pkg::DATA_W-1] ? (~in_chan.dividend + 1'b1)
                                                          : in_chan.dividend;
          den_nxt   = in_chan.divisor[sid_pkg::DATA_W-1] ? (~in_chan.divisor + 1'b1)
                                                         : in_chan.divisor;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          neg_nxt   = in_chan.dividend[sid_pkg::DATA_W-1] ^ in_chan.divisor[sid_pkg::DATA_W-1];
          dbz_nxt   = (in_chan.divisor == '0);
          state_nxt = sid_pkg::ST_RUN;
        end
      end
      sid_pkg::ST_RUN: begin
        if (trial[sid_pkg::DATA_W]) begin
          rem_nxt = {rem_r[sid_pkg::DATA_W-2:0], quo_r[sid_pkg::DATA_W-1]};
          quo_nxt = {quo_r[sid_pkg::DATA_W-2:0], 1'b0};
        end else begin
          rem_nxt = trial[sid_pkg::DATA_W-1:0];
          quo_nxt = {quo_r[sid_pkg::DATA_W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == sid_pkg::LAST_STEP) begin
          state_nxt = sid_pkg::ST_FIN;
        end
      end
      sid_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_quot_nxt  = dbz_r ? '0 : q_fixed;
          out_dbz_nxt   = dbz_r;
          state_nxt     = sid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sid_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    dbz_r      <= dbz_nxt;
    out_quot_r <= out_quot_nxt;
    out_dbz_r  <= out_dbz_nxt;
  end

endmodule

// ----- design/sid_checker.sv -----
// port-level checks for the divider, bound to the divider core
module sid_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [31:0]           out_quotient,
  input logic                  out_div_by_zero
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_quotient) && $stable(out_div_by_zero))
    else $error("stalled result changed");

  // zero divisor always reports a zero quotient
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_quotient == 32'd0)
    else $error("zero divisor with nonzero quotient");

  // loop is busy right after an operand transfer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("operand taken while loop busy");

endmodule

bind signed_integer_divider_core sid_checker u_sid_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_quotient    (out_chan.quotient),
  .out_div_by_zero (out_chan.div_by_zero)
);
